FILE: rtl/ioib_pkg.sv
// Shared constants and types for the in-order release buffer.
package ioib_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned CharsDefault = 5;
  localparam int unsigned CharBits     = 8;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StRun
  } state_e;

endpackage

FILE: rtl/ioib_slot_ram.sv
// Slot memory: one write port, one registered read port, word = {valid, payload}.
module ioib_slot_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned PayW  = 40
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wvalid_i,
  input  logic [PayW-1:0]  wpayload_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rvalid_o,
  output logic [PayW-1:0]  rpayload_o
);

  logic [PayW:0] mem_q [Depth];
  logic [PayW:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wvalid_i, wpayload_i};
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rvalid_o   = rdata_q[PayW];
  assign rpayload_o = rdata_q[PayW-1:0];

endmodule

FILE: rtl/in_order_release_buffer_unit.sv
// Top level of the in-order release buffer: release sequencer around the slot memory.
//
// Usage: drive position_i and payload_i and raise start_i; the word is taken at a
// rising edge where start_i is high and busy_o is low. The payload goes into slot
// position_i (positions 1..DEPTH; anything else is dropped). If that position is
// the next one due for release, the block releases it and every consecutive filled
// slot after it, one result word per cycle on out_payload_o / out_position_o,
// each marked by valid_o for exactly one cycle; last_o flags the final word of
// the run. The receiver cannot stall, so results are never held back.
// Release timing: a word that releases nothing leaves busy_o low. A word that starts
// a run of k releases shows its first result in the cycle after acceptance and keeps
// busy_o high until the run ends; the pace is set by the single memory read port,
// one slot read per released word.
// Reset: the release pointer returns to 1 and a clearing pass sweeps all DEPTH
// slots, one per cycle, with busy_o high; input is taken once the pass is done.
// After position DEPTH is released, later words are stored but never released.
module in_order_release_buffer_unit
  import ioib_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned CHARS = CharsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [$clog2(DEPTH+1)-1:0]       position_i,
  input  logic [CharBits*CHARS-1:0]        payload_i,
  output logic                             valid_o,
  output logic [CharBits*CHARS-1:0]        out_payload_o,
  output logic [$clog2(DEPTH+1)-1:0]       out_position_o,
  output logic                             last_o
);

  localparam int unsigned PosW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned PayW  = CharBits * CHARS;

  localparam logic [PosW-1:0]  DepthPos = PosW'(DEPTH);
  localparam logic [PosW-1:0]  OnePos   = PosW'(1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);

  state_e state_q, state_d;

  // Release pointer: position of the next slot due, 1..DEPTH+1.
  logic [PosW-1:0]  nr_q, nr_d;
  logic [AddrW-1:0] clr_q, clr_d;

  // Word waiting to go out; its last flag depends on the following slot.
  logic [PayW-1:0]  pend_pay_q, pend_pay_d;
  logic [PosW-1:0]  pend_pos_q, pend_pos_d;

  logic             accept;
  logic             pos_ok;
  logic             start_run;
  logic [PosW-1:0]  pos_m1;
  logic             cand_valid;

  logic             we;
  logic [AddrW-1:0] waddr;
  logic             wvalid;
  logic [AddrW-1:0] raddr;
  logic             rvalid;
  logic [PayW-1:0]  rpayload;

  assign accept    = start_i && (state_q == StIdle);
  assign pos_ok    = (position_i != '0) && (position_i <= DepthPos);
  assign start_run = accept && pos_ok && (position_i == nr_q);
  assign pos_m1    = position_i - OnePos;

  // Slot read in this cycle is position nr_q+1, i.e. index nr_q; clamp past the end.
  assign raddr = (nr_q < DepthPos) ? nr_q[AddrW-1:0] : '0;

  // Data for position nr_q arrives now; it only counts inside the buffer range.
  assign cand_valid = (nr_q <= DepthPos) && rvalid;

  // Write port: clearing pass after reset, otherwise store accepted words.
  always_comb begin
    we     = 1'b0;
    waddr  = pos_m1[AddrW-1:0];
    wvalid = 1'b1;
    if (state_q == StClear) begin
      we     = 1'b1;
      waddr  = clr_q;
      wvalid = 1'b0;
    end else if (accept && pos_ok) begin
      we = 1'b1;
    end
  end

  ioib_slot_ram #(
    .Depth (DEPTH),
    .AddrW (AddrW),
    .PayW  (PayW)
  ) u_slot_ram (
    .clk_i      (clk_i),
    .we_i       (we),
    .waddr_i    (waddr),
    .wvalid_i   (wvalid),
    .wpayload_i (payload_i),
    .raddr_i    (raddr),
    .rvalid_o   (rvalid),
    .rpayload_o (rpayload)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_run) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (!cand_valid) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o         = 1'b1;
    valid_o        = 1'b0;
    last_o         = 1'b0;
    out_payload_o  = pend_pay_q;
    out_position_o = pend_pos_q;
    unique case (state_q)
      StClear: busy_o = 1'b1;
      StIdle:  busy_o = 1'b0;
      StRun: begin
        valid_o = 1'b1;
        last_o  = !cand_valid;
      end
      default: busy_o = 1'b1;
    endcase
  end

  // Pointer, sweep counter and pending word.
  always_comb begin
    nr_d       = nr_q;
    clr_d      = clr_q;
    pend_pay_d = pend_pay_q;
    pend_pos_d = pend_pos_q;
    if (state_q == StClear) begin
      clr_d = clr_q + AddrW'(1);
    end
    if (start_run) begin
      // advance past the slot just written; it goes out next cycle
      pend_pay_d = payload_i;
      pend_pos_d = position_i;
      nr_d       = nr_q + OnePos;
    end else if (state_q == StRun && cand_valid) begin
      pend_pay_d = rpayload;
      pend_pos_d = nr_q;
      nr_d       = nr_q + OnePos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      nr_q    <= OnePos;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      nr_q    <= nr_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_pay_q <= pend_pay_d;
    pend_pos_q <= pend_pos_d;
  end

endmodule
